// ===== hdl/sha256_stream_hasher_defines.svh =====
// Assertion macros for the hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst, a, c)
`define SHA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/sha_pkg.sv =====
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  localparam word_t Init [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha256_stream_hasher.sv =====
// Absorb word: a queued byte is taken in S_TAKE; every 64th byte starts a compression (64 rounds).
// Finish: the 0x80 byte and zero padding fill the block, then a compression; if the length
// does not fit, a full pad block and a second compression follow,
// then 8 digest words, one per cycle while m_axis_tready is high.
// Sustained rate is set by the single round unit; intake stalls during compression.
// Synchronous active-high rst restores the initial hash and clears counts.
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last
);
  sha_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;

  assign in_item.op        = s_axis_tuser;
  assign in_item.data_byte = s_axis_tdata;

  sha_queue u_queue (
    .clk, .rst,
    .wr_valid (s_axis_tvalid), .wr_ready (s_axis_tready), .wr_item (in_item),
    .rd_valid (q_valid), .rd_ready (q_ready), .rd_item (q_item)
  );

  sha_core u_core (
    .clk, .rst,
    .item_valid (q_valid), .item_ready (q_ready), .item (q_item),
    .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
    .out_word (m_axis_tdata), .out_index (m_axis_tuser), .out_last (m_axis_tlast)
  );

  `SHA_ASSERT_IMP(a_last_idx, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 3'd7)
  `SHA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SHA_ASSERT_IMP(a_no_take, clk, rst, m_axis_tvalid, !q_ready)
endmodule

// ===== hdl/sha_queue.sv =====
module sha_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  sha_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output sha_pkg::item_t rd_item
);
  localparam int AW = $clog2(sha_pkg::QueueDepth);

  sha_pkg::item_t   slots [sha_pkg::QueueDepth];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != AW'(0) + (AW+1)'(sha_pkg::QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== hdl/sha_core.sv =====
// Back end: packs bytes, pads, runs one round a cycle, emits the digest.
module sha_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  sha_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_word,
  output logic [2:0]     out_index,
  output logic           out_last
);
  typedef enum logic [2:0] {
    S_TAKE, S_PAD, S_INIT, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t         state;
  sha_pkg::word_t chain [8];
  sha_pkg::word_t v     [8];
  sha_pkg::word_t w     [16];
  logic [5:0]     fill;
  logic [63:0]    bits;
  logic [5:0]     rnd;
  logic           finishing;
  logic           final_block;
  logic [2:0]     idx;
  logic [63:0]    len_bits;

  // byte entering the current word slot
  logic [7:0]     in_byte;
  sha_pkg::word_t wnew, s0, s1, t1, t2;

  assign len_bits   = bits;
  assign item_ready = (state == S_TAKE);

  always_comb begin
    if (state == S_PAD) begin
      if (fill >= 6'd56 && final_block) begin
        in_byte = len_bits[8'(8'd63 - {fill[2:0], 3'b0}) -: 8];
      end else begin
        in_byte = 8'h00;
      end
    end else if (item.op) begin
      in_byte = 8'h80;
    end else begin
      in_byte = item.data_byte;
    end
  end

  always_comb begin
    s0 = sha_pkg::rotr(w[1], 7) ^ sha_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::rotr(w[14], 17) ^ sha_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = (rnd < 6'd16) ? w[0] : (w[0] + s0 + w[9] + s1);
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[rnd] + wnew;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign out_valid = (state == S_EMIT);
  assign out_word  = chain[idx];
  assign out_index = idx;
  assign out_last  = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_TAKE;
      fill      <= '0;
      bits      <= '0;
      finishing <= 1'b0;
      final_block <= 1'b0;
      rnd       <= '0;
      idx       <= '0;
      for (int j = 0; j < 8; j++) chain[j] <= sha_pkg::Init[j];
    end else begin
      unique case (state)
        S_TAKE: begin
          if (item_valid) begin
            // schedule buffer shifts one byte into the low end of w[fill/4]
            w[fill[5:2]] <= {w[fill[5:2]][23:0], in_byte};
            fill <= fill + 6'd1;
            if (item.op) begin
              finishing   <= 1'b1;
              // length fits when the 0x80 byte lands at or below byte 55
              final_block <= (fill < 6'd56);
              state       <= (fill == 6'd63) ? S_INIT : S_PAD;
            end else begin
              bits <= bits + 64'd8;
              if (fill == 6'd63) state <= S_INIT;
            end
          end
        end
        S_PAD: begin
          w[fill[5:2]] <= {w[fill[5:2]][23:0], in_byte};
          fill <= fill + 6'd1;
          if (fill == 6'd63) state <= S_INIT;
        end
        S_INIT: begin
          for (int j = 0; j < 8; j++) v[j] <= chain[j];
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int j = 0; j < 15; j++) w[j] <= w[j+1];
          w[15] <= wnew;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int j = 0; j < 8; j++) chain[j] <= chain[j] + v[j];
          if (!finishing) begin
            state <= S_TAKE;
          end else if (final_block) begin
            idx   <= '0;
            state <= S_EMIT;
          end else begin
            final_block <= 1'b1;
            state       <= S_PAD;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int j = 0; j < 8; j++) chain[j] <= sha_pkg::Init[j];
              bits      <= '0;
              fill      <= '0;
              finishing <= 1'b0;
              state     <= S_TAKE;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // digest_word
  logic [2:0]  m_axis_tuser;   // word_index
  logic        m_axis_tlast;   // last

  sha256_stream_hasher u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // hash model state
  sha_pkg::word_t hash_h [8];
  logic [7:0]     msg_block [64];
  int             fill;
  logic [63:0]    msg_bytes;

  digest_word_t digest_q [$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 0;

  function automatic sha_pkg::word_t ror32(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    sha_pkg::word_t w [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    v = hash_h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_h[j] += v[j];
  endtask

  task automatic hash_restart();
    hash_h = sha_pkg::Init;
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic hash_step(logic op, logic [7:0] b);
    logic [63:0] bits;
    digest_word_t d;
    if (op == OP_ABSORB) begin
      msg_block[fill] = b;
      fill++;
      msg_bytes++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end else begin
      bits = msg_bytes << 3;
      msg_block[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) msg_block[fill++] = 8'h00;
        compress_block();
        fill = 0;
      end
      while (fill < 56) msg_block[fill++] = 8'h00;
      for (int j = 0; j < 8; j++) msg_block[56+j] = bits[63-8*j -: 8];
      compress_block();
      for (int j = 0; j < 8; j++) begin
        d.word = hash_h[j];
        d.index = j[2:0];
        d.last = (j == 7);
        digest_q.push_back(d);
      end
      hash_restart();
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sender: drive at falling edge, hold until accepted
  task automatic send_word(logic op, logic [7:0] b);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    hash_step(op, b);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst || hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected word %h idx %0d last %0b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        digest_word_t e;
        e = digest_q.pop_front();
        if (m_axis_tdata !== e.word || m_axis_tuser !== e.index
            || m_axis_tlast !== e.last) begin
          $display("%0t: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                   $time, e.word, e.index, e.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // directed rows: {op, byte, check_digest0, digest0}
  typedef struct {
    logic        op;
    logic [7:0]  b;
    bit          known;
    logic [31:0] word0;
  } row_t;

  row_t rows [$];

  task automatic send_message(int len, bit pattern);
    for (int i = 0; i < len; i++)
      send_word(OP_ABSORB, pattern ? 8'(i) : 8'($urandom_range(255)));
    send_word(OP_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int n;
    int len;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    hash_restart();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty message, "abc", then extremes of the byte and op with junk data
    rows.push_back('{OP_FINISH, 8'hff, 1, 32'he3b0c442});
    rows.push_back('{OP_ABSORB, 8'h61, 0, 0});
    rows.push_back('{OP_ABSORB, 8'h62, 0, 0});
    rows.push_back('{OP_ABSORB, 8'h63, 0, 0});
    rows.push_back('{OP_FINISH, 8'h00, 1, 32'hba7816bf});
    rows.push_back('{OP_ABSORB, 8'h00, 0, 0});
    rows.push_back('{OP_ABSORB, 8'hff, 0, 0});
    rows.push_back('{OP_ABSORB, 8'haa, 0, 0});
    rows.push_back('{OP_ABSORB, 8'h55, 0, 0});
    rows.push_back('{OP_FINISH, 8'h5a, 0, 0});
    foreach (rows[i]) begin
      if (rows[i].known && rows[i].word0 !== sha_pkg::Init[0]) begin
        // first digest word after this finish is known up front
        n = digest_q.size();
        send_word(rows[i].op, rows[i].b);
        if (digest_q[n].word !== rows[i].word0) begin
          $display("%0t: expected %h, got %h (model)", $time, rows[i].word0,
                   digest_q[n].word);
          errors++;
        end
      end else begin
        send_word(rows[i].op, rows[i].b);
      end
    end
    // padding boundaries: 55, 56, 63, 64 bytes
    send_message(55, 1);
    send_message(56, 1);
    send_message(63, 1);
    send_message(64, 1);
    drain();

    // random phases
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      while (n < 50 * (ph + 1)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
        send_message(len, 0);
        n += len + 1;
      end
      drain();
    end

    // long receiver hold-off while the sender keeps going
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int k = 0; k < 6; k++) send_message($urandom_range(5), 0);
      end
    join
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
